>>> rtl/sobel_pkg.sv
// Shared types and constants for the Sobel edge threshold block.
`timescale 1ns / 1ps
`default_nettype none

package sobel_pkg;

  localparam int unsigned MAX_LINE_LENGTH_DEF = 1024;
  localparam int unsigned MAX_LINE_COUNT_DEF  = 1024;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned CFG_W  = 11;
  localparam int unsigned SUM_W  = 10;
  localparam int unsigned MAG_W  = 11;
  localparam int unsigned IDX_W  = 2;

  localparam logic [CFG_W-1:0] THRESHOLD_RST   = 11'd360;
  localparam logic [CFG_W-1:0] LINE_LENGTH_RST = 11'd1024;
  localparam logic [CFG_W-1:0] LINE_COUNT_RST  = 11'd1024;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;
  localparam int unsigned QUEUE_CW    = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_EDGE_THRESHOLD = 2'd0,
    REG_LINE_LENGTH    = 2'd1,
    REG_LINE_COUNT     = 2'd2
  } reg_index_t;

  // weighted column/row sums of one window, as handed from front to back
  typedef struct packed {
    logic             win_valid;
    logic [SUM_W-1:0] top;
    logic [SUM_W-1:0] bot;
    logic [SUM_W-1:0] left;
    logic [SUM_W-1:0] right;
  } sums_t;

  typedef struct packed {
    logic             win_valid;
    logic             edge_res;
    logic [MAG_W-1:0] magnitude;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/sobel_front.sv
// Front end: raster counters, two line stores, 3x3 window and weighted sums.
`timescale 1ns / 1ps
`default_nettype none

module sobel_front #(
  parameter int unsigned MAX_LINE_LENGTH = sobel_pkg::MAX_LINE_LENGTH_DEF,
  parameter int unsigned MAX_LINE_COUNT  = sobel_pkg::MAX_LINE_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic [sobel_pkg::PIX_W-1:0]   pixel,
  input  wire logic [sobel_pkg::CFG_W-1:0]   line_length,
  input  wire logic [sobel_pkg::CFG_W-1:0]   line_count,
  output logic                               busy,
  output sobel_pkg::sums_t                   sums
);

  localparam int unsigned PW = $clog2(MAX_LINE_LENGTH);
  localparam int unsigned LW = $clog2(MAX_LINE_LENGTH + 1);
  localparam int unsigned RW = $clog2(MAX_LINE_COUNT);
  localparam int unsigned CW = $clog2(MAX_LINE_COUNT + 1);

  logic [sobel_pkg::PIX_W-1:0] near_mem [MAX_LINE_LENGTH];
  logic [sobel_pkg::PIX_W-1:0] far_mem  [MAX_LINE_LENGTH];

  logic [PW-1:0] pos;
  logic [RW-1:0] row;
  logic [LW-1:0] len_c;
  logic [CW-1:0] cnt_c;

  logic                        s1_valid;
  logic [PW-1:0]               s1_pos;
  logic [sobel_pkg::PIX_W-1:0] s1_pix;
  logic                        s1_win;
  logic [sobel_pkg::PIX_W-1:0] rd_near;
  logic [sobel_pkg::PIX_W-1:0] rd_far;

  logic [sobel_pkg::PIX_W-1:0] w0, w1, w2, w3, w4, w5;

  always_comb begin
    if (line_length < 11'd3) begin
      len_c = LW'(3);
    end else if (32'(line_length) > 32'(MAX_LINE_LENGTH)) begin
      len_c = LW'(MAX_LINE_LENGTH);
    end else begin
      len_c = LW'(line_length);
    end
    if (line_count < 11'd3) begin
      cnt_c = CW'(3);
    end else if (32'(line_count) > 32'(MAX_LINE_COUNT)) begin
      cnt_c = CW'(MAX_LINE_COUNT);
    end else begin
      cnt_c = CW'(line_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (LW'(pos) >= len_c - LW'(1)) begin
          pos <= '0;
          if (CW'(row) >= cnt_c - CW'(1)) begin
            row <= '0;
          end else begin
            row <= row + RW'(1);
          end
        end else begin
          pos <= pos + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos <= pos;
      s1_pix <= pixel;
      s1_win <= (pos >= PW'(2)) && (row >= RW'(2));
    end
  end

  // line stores: read on accept, written back in the following cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_near <= near_mem[pos];
    end
    if (s1_valid) begin
      near_mem[s1_pos] <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_far <= far_mem[pos];
    end
    if (s1_valid) begin
      far_mem[s1_pos] <= rd_near;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w0 <= '0;
      w1 <= '0;
      w2 <= '0;
      w3 <= '0;
      w4 <= '0;
      w5 <= '0;
    end else if (s1_valid) begin
      w3 <= w0;
      w4 <= w1;
      w5 <= w2;
      w0 <= rd_far;
      w1 <= rd_near;
      w2 <= s1_pix;
    end
  end

  always_comb begin
    sums.win_valid = s1_win;
    sums.top   = sobel_pkg::SUM_W'(w3) + {1'b0, w0, 1'b0} + sobel_pkg::SUM_W'(rd_far);
    sums.bot   = sobel_pkg::SUM_W'(w5) + {1'b0, w2, 1'b0} + sobel_pkg::SUM_W'(s1_pix);
    sums.left  = sobel_pkg::SUM_W'(w3) + {1'b0, w4, 1'b0} + sobel_pkg::SUM_W'(w5);
    sums.right = sobel_pkg::SUM_W'(rd_far) + {1'b0, rd_near, 1'b0}
               + sobel_pkg::SUM_W'(s1_pix);
  end

  assign busy = s1_valid;

endmodule

`default_nettype wire

>>> rtl/sobel_queue.sv
// Short word queue between front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module sobel_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        wr,
  input  wire sobel_pkg::sums_t            wr_data,
  input  wire logic                        rd,
  output sobel_pkg::sums_t                 rd_data,
  output logic [sobel_pkg::QUEUE_CW-1:0]   count
);

  sobel_pkg::sums_t mem [sobel_pkg::QUEUE_DEPTH];

  logic [sobel_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [sobel_pkg::QUEUE_AW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + sobel_pkg::QUEUE_AW'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + sobel_pkg::QUEUE_AW'(1);
      end
      if (wr && !rd) begin
        count <= count + sobel_pkg::QUEUE_CW'(1);
      end else if (rd && !wr) begin
        count <= count - sobel_pkg::QUEUE_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  assign rd_data = mem[rd_ptr];

endmodule

`default_nettype wire

>>> rtl/sobel_back.sv
// Back end: gradient magnitude, threshold compare and output word register.
`timescale 1ns / 1ps
`default_nettype none

module sobel_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [sobel_pkg::CFG_W-1:0]  edge_threshold,
  input  wire logic                         q_avail,
  input  wire sobel_pkg::sums_t             q_data,
  output logic                              q_take,
  input  wire logic                         pop,
  output logic                              empty,
  output sobel_pkg::result_t                res
);

  logic                                  out_full;
  logic signed [sobel_pkg::SUM_W:0]      dx;
  logic signed [sobel_pkg::SUM_W:0]      dy;
  logic [sobel_pkg::SUM_W-1:0]           adx;
  logic [sobel_pkg::SUM_W-1:0]           ady;
  logic [sobel_pkg::MAG_W-1:0]           mag;
  sobel_pkg::result_t                    res_next;

  always_comb begin
    dx  = $signed({1'b0, q_data.bot})   - $signed({1'b0, q_data.top});
    dy  = $signed({1'b0, q_data.right}) - $signed({1'b0, q_data.left});
    adx = dx[sobel_pkg::SUM_W] ? sobel_pkg::SUM_W'(-dx) : sobel_pkg::SUM_W'(dx);
    ady = dy[sobel_pkg::SUM_W] ? sobel_pkg::SUM_W'(-dy) : sobel_pkg::SUM_W'(dy);
    mag = sobel_pkg::MAG_W'(adx) + sobel_pkg::MAG_W'(ady);
    res_next.win_valid = q_data.win_valid;
    res_next.magnitude = q_data.win_valid ? mag : '0;
    res_next.edge_res  = q_data.win_valid && (mag > edge_threshold);
  end

  assign q_take = q_avail && (!out_full || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (q_take) begin
      out_full <= 1'b1;
    end else if (pop) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      res <= res_next;
    end
  end

  assign empty = !out_full;

endmodule

`default_nettype wire

>>> rtl/sobel_edge_threshold_top.sv
// Top level of the Sobel 3x3 edge threshold block.
//
// Pixels enter in raster order through a queue-style port: a word is taken
// when push is high and full is low. Each pixel yields one result word,
// presented while empty is low and taken when pop is high.
// The front end reads both line stores on the cycle a pixel is taken, builds
// the 3x3 window on the next cycle and hands weighted sums into a four-word
// queue; the back end forms |dx|+|dy|, compares with edge_threshold and holds
// the word in an output register. Each word passes the window stage, queue
// and output register; one pixel per cycle is sustained while pop keeps up,
// the rate being set by the single read and write port of each line store.
// When pop stalls, the queue and output register absorb up to five words;
// full then rises and holds further pixels off until space frees.
// Synchronous reset empties the pipeline, zeroes the raster counters and
// window, and loads threshold 360 and geometry 1024 x 1024. Line stores are
// not cleared. Configuration writes take effect at once and should be made
// while no words are in flight.
`timescale 1ns / 1ps
`default_nettype none

module sobel_edge_threshold_top #(
  parameter int unsigned MAX_LINE_LENGTH = sobel_pkg::MAX_LINE_LENGTH_DEF,
  parameter int unsigned MAX_LINE_COUNT  = sobel_pkg::MAX_LINE_COUNT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [sobel_pkg::PIX_W-1:0]  pixel,
  output logic                              empty,
  input  wire logic                         pop,
  output logic                              window_valid,
  output logic                              edge_res,
  output logic [sobel_pkg::MAG_W-1:0]       magnitude,
  input  wire logic                         cfg_we,
  input  wire logic [sobel_pkg::IDX_W-1:0]  cfg_idx,
  input  wire logic [sobel_pkg::CFG_W-1:0]  cfg_data
);

  logic [sobel_pkg::CFG_W-1:0] edge_threshold;
  logic [sobel_pkg::CFG_W-1:0] line_length;
  logic [sobel_pkg::CFG_W-1:0] line_count;

  logic                             accept;
  logic                             front_busy;
  sobel_pkg::sums_t                 front_sums;
  sobel_pkg::sums_t                 q_data;
  logic                             q_take;
  logic [sobel_pkg::QUEUE_CW-1:0]   q_count;
  logic [sobel_pkg::QUEUE_CW:0]     in_flight;
  sobel_pkg::result_t               res;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_threshold <= sobel_pkg::THRESHOLD_RST;
      line_length    <= sobel_pkg::LINE_LENGTH_RST;
      line_count     <= sobel_pkg::LINE_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        sobel_pkg::REG_EDGE_THRESHOLD: edge_threshold <= cfg_data;
        sobel_pkg::REG_LINE_LENGTH:    line_length    <= cfg_data;
        sobel_pkg::REG_LINE_COUNT:     line_count     <= cfg_data;
        default: ;
      endcase
    end
  end

  // words in the window stage plus words queued must leave room
  assign in_flight = {1'b0, q_count} + (sobel_pkg::QUEUE_CW + 1)'(front_busy);
  assign full      = in_flight >= (sobel_pkg::QUEUE_CW + 1)'(sobel_pkg::QUEUE_DEPTH);
  assign accept    = push && !full;

  sobel_front #(
    .MAX_LINE_LENGTH (MAX_LINE_LENGTH),
    .MAX_LINE_COUNT  (MAX_LINE_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pixel       (pixel),
    .line_length (line_length),
    .line_count  (line_count),
    .busy        (front_busy),
    .sums        (front_sums)
  );

  sobel_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (front_busy),
    .wr_data (front_sums),
    .rd      (q_take),
    .rd_data (q_data),
    .count   (q_count)
  );

  sobel_back u_back (
    .clk            (clk),
    .rst            (rst),
    .edge_threshold (edge_threshold),
    .q_avail        (q_count != '0),
    .q_data         (q_data),
    .q_take         (q_take),
    .pop            (pop),
    .empty          (empty),
    .res            (res)
  );

  assign window_valid = res.win_valid;
  assign edge_res     = res.edge_res;
  assign magnitude    = res.magnitude;

endmodule

`default_nettype wire
